// ----- sv/irbs_pkg.sv -----
// Shared constants for the IR beacon servo seek block: command, class and code
// values, configuration register indexes and register reset values.
// No dependencies.
`default_nettype none

package irbs_pkg;

    localparam int LEVEL_BITS_DEF = 10;
    localparam int WIDTH_BITS_DEF = 12;

    localparam int CMD_BITS   = 2;
    localparam int CLASS_BITS = 2;
    localparam int CODE_BITS  = 2;
    localparam int MODE_BITS  = 3;
    localparam int STEP_BITS  = 8;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_START  = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_STOP   = 2'd3;

    localparam logic [CLASS_BITS-1:0] CLASS_NONE = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLASS_BOT  = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLASS_GOAL = 2'd2;

    localparam logic [CODE_BITS-1:0] CODE_NONE  = 2'd0;
    localparam logic [CODE_BITS-1:0] CODE_BOTH  = 2'd1;
    localparam logic [CODE_BITS-1:0] CODE_LEFT  = 2'd2;
    localparam logic [CODE_BITS-1:0] CODE_RIGHT = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BOT_LOW   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BOT_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GOAL_LOW  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GOAL_HIGH = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_MIN = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_MAX = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_HOME = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_STEP = 3'd7;

    localparam int BOT_LOW_RST    = 240;
    localparam int BOT_HIGH_RST   = 320;
    localparam int GOAL_LOW_RST   = 425;
    localparam int GOAL_HIGH_RST  = 515;
    localparam int WIDTH_MIN_RST  = 590;
    localparam int WIDTH_MAX_RST  = 1500;
    localparam int WIDTH_HOME_RST = 1485;
    localparam int WIDTH_STEP_RST = 10;

endpackage

`default_nettype wire

// ----- sv/ir_beacon_servo_seek.sv -----
// Top level of the IR beacon servo seek block: input beat register, output valid
// and packing. Depends on irbs_pkg, irbs_cfg_regs and irbs_seek_core.
//
//  Channel   Direction  Handshake              Payload
//  s         in         i_s_tvalid/o_s_tready  tuser command, tdata sensor levels etc.
//  m         out        o_m_tvalid/i_m_tready  tdata servo width, mode, code, flags
//  cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One beat is accepted every cycle while the output is not stalled; its result passes through
// the input register followed by the state and result registers.
// Reset restores the configuration defaults and the seek state; no clearing pass.
// A stalled output holds the state; the input register keeps taking a beat while the
// result waits, and further beats wait until the result is taken.
`default_nettype none

module ir_beacon_servo_seek #(
    parameter int LEVEL_BITS = irbs_pkg::LEVEL_BITS_DEF,
    parameter int WIDTH_BITS = irbs_pkg::WIDTH_BITS_DEF,
    parameter int IN_BYTES   = (2 * LEVEL_BITS + 3 + 7) / 8,
    parameter int OUT_BYTES  = (WIDTH_BITS + 8 + 7) / 8,
    parameter int DATA_BITS  = (WIDTH_BITS > LEVEL_BITS) ? WIDTH_BITS : LEVEL_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // tdata: left_level, right_level, target_select, park_low, zero fill
    input  wire logic [8*IN_BYTES-1:0]               i_s_tdata,
    // tuser: command
    input  wire logic [irbs_pkg::CMD_BITS-1:0]       i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // tdata: servo_width, servo_update, mode, sensed_code, sense_changed,
    // deploy_request, zero fill
    output logic [8*OUT_BYTES-1:0]                   o_m_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [irbs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [DATA_BITS-1:0]                i_cfg_data
);

    localparam int OUT_USED = WIDTH_BITS + 8;

    logic                            r_in_valid;
    logic [irbs_pkg::CMD_BITS-1:0]   r_command;
    logic [LEVEL_BITS-1:0]           r_left, r_right;
    logic [1:0]                      r_tsel;
    logic                            r_park;
    logic                            r_out_valid;
    logic                            advance;
    logic                            s_take;

    logic [LEVEL_BITS-1:0]           bot_low, bot_high, goal_low, goal_high;
    logic [WIDTH_BITS-1:0]           width_min, width_max, width_home;
    logic [irbs_pkg::STEP_BITS-1:0]  width_step;

    logic [WIDTH_BITS-1:0]           servo_width;
    logic                            servo_update, sense_changed, deploy_request;
    logic [irbs_pkg::MODE_BITS-1:0]  mode;
    logic [irbs_pkg::CODE_BITS-1:0]  sensed_code;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_take     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_command <= i_s_tuser;
            r_left    <= i_s_tdata[LEVEL_BITS-1:0];
            r_right   <= i_s_tdata[2*LEVEL_BITS-1:LEVEL_BITS];
            r_tsel    <= i_s_tdata[2*LEVEL_BITS+1:2*LEVEL_BITS];
            r_park    <= i_s_tdata[2*LEVEL_BITS+2];
        end
    end

    irbs_cfg_regs #(
        .LEVEL_BITS (LEVEL_BITS),
        .WIDTH_BITS (WIDTH_BITS),
        .DATA_BITS  (DATA_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_bot_low    (bot_low),
        .o_bot_high   (bot_high),
        .o_goal_low   (goal_low),
        .o_goal_high  (goal_high),
        .o_width_min  (width_min),
        .o_width_max  (width_max),
        .o_width_home (width_home),
        .o_width_step (width_step)
    );

    irbs_seek_core #(
        .LEVEL_BITS (LEVEL_BITS),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_command        (r_command),
        .i_left_level     (r_left),
        .i_right_level    (r_right),
        .i_target_select  (r_tsel),
        .i_park_low       (r_park),
        .i_bot_low        (bot_low),
        .i_bot_high       (bot_high),
        .i_goal_low       (goal_low),
        .i_goal_high      (goal_high),
        .i_width_min      (width_min),
        .i_width_max      (width_max),
        .i_width_home     (width_home),
        .i_width_step     (width_step),
        .o_servo_width    (servo_width),
        .o_servo_update   (servo_update),
        .o_mode           (mode),
        .o_sensed_code    (sensed_code),
        .o_sense_changed  (sense_changed),
        .o_deploy_request (deploy_request)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(8*OUT_BYTES-OUT_USED)'(0), deploy_request, sense_changed,
                         sensed_code, mode, servo_update, servo_width};

endmodule

`default_nettype wire

// ----- sv/irbs_cfg_regs.sv -----
// Configuration register file of the IR beacon servo seek block.
// Depends on irbs_pkg for register indexes and reset values.
`default_nettype none

module irbs_cfg_regs #(
    parameter int LEVEL_BITS = irbs_pkg::LEVEL_BITS_DEF,
    parameter int WIDTH_BITS = irbs_pkg::WIDTH_BITS_DEF,
    parameter int DATA_BITS  = (WIDTH_BITS > LEVEL_BITS) ? WIDTH_BITS : LEVEL_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [irbs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [DATA_BITS-1:0]                i_cfg_data,
    output logic [LEVEL_BITS-1:0]                    o_bot_low,
    output logic [LEVEL_BITS-1:0]                    o_bot_high,
    output logic [LEVEL_BITS-1:0]                    o_goal_low,
    output logic [LEVEL_BITS-1:0]                    o_goal_high,
    output logic [WIDTH_BITS-1:0]                    o_width_min,
    output logic [WIDTH_BITS-1:0]                    o_width_max,
    output logic [WIDTH_BITS-1:0]                    o_width_home,
    output logic [irbs_pkg::STEP_BITS-1:0]           o_width_step
);

    logic [LEVEL_BITS-1:0]          r_bot_low, r_bot_high, r_goal_low, r_goal_high;
    logic [WIDTH_BITS-1:0]          r_width_min, r_width_max, r_width_home;
    logic [irbs_pkg::STEP_BITS-1:0] r_width_step;
    logic                           wr;

    assign o_cfg_ready = 1'b1;
    assign wr = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bot_low    <= LEVEL_BITS'(irbs_pkg::BOT_LOW_RST);
            r_bot_high   <= LEVEL_BITS'(irbs_pkg::BOT_HIGH_RST);
            r_goal_low   <= LEVEL_BITS'(irbs_pkg::GOAL_LOW_RST);
            r_goal_high  <= LEVEL_BITS'(irbs_pkg::GOAL_HIGH_RST);
            r_width_min  <= WIDTH_BITS'(irbs_pkg::WIDTH_MIN_RST);
            r_width_max  <= WIDTH_BITS'(irbs_pkg::WIDTH_MAX_RST);
            r_width_home <= WIDTH_BITS'(irbs_pkg::WIDTH_HOME_RST);
            r_width_step <= irbs_pkg::STEP_BITS'(irbs_pkg::WIDTH_STEP_RST);
        end else if (wr) begin
            case (i_cfg_index)
                irbs_pkg::REG_BOT_LOW:    r_bot_low    <= i_cfg_data[LEVEL_BITS-1:0];
                irbs_pkg::REG_BOT_HIGH:   r_bot_high   <= i_cfg_data[LEVEL_BITS-1:0];
                irbs_pkg::REG_GOAL_LOW:   r_goal_low   <= i_cfg_data[LEVEL_BITS-1:0];
                irbs_pkg::REG_GOAL_HIGH:  r_goal_high  <= i_cfg_data[LEVEL_BITS-1:0];
                irbs_pkg::REG_WIDTH_MIN:  r_width_min  <= i_cfg_data[WIDTH_BITS-1:0];
                irbs_pkg::REG_WIDTH_MAX:  r_width_max  <= i_cfg_data[WIDTH_BITS-1:0];
                irbs_pkg::REG_WIDTH_HOME: r_width_home <= i_cfg_data[WIDTH_BITS-1:0];
                irbs_pkg::REG_WIDTH_STEP: begin
                    r_width_step <= i_cfg_data[irbs_pkg::STEP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_bot_low    = r_bot_low;
    assign o_bot_high   = r_bot_high;
    assign o_goal_low   = r_goal_low;
    assign o_goal_high  = r_goal_high;
    assign o_width_min  = r_width_min;
    assign o_width_max  = r_width_max;
    assign o_width_home = r_width_home;
    assign o_width_step = r_width_step;

endmodule

`default_nettype wire

// ----- sv/irbs_classify.sv -----
// Sensor level classifier: tests one level against the bot and goal windows.
// Depends on irbs_pkg for the class codes.
`default_nettype none

module irbs_classify #(
    parameter int LEVEL_BITS = irbs_pkg::LEVEL_BITS_DEF
) (
    input  wire logic [LEVEL_BITS-1:0]           i_level,
    input  wire logic [LEVEL_BITS-1:0]           i_bot_low,
    input  wire logic [LEVEL_BITS-1:0]           i_bot_high,
    input  wire logic [LEVEL_BITS-1:0]           i_goal_low,
    input  wire logic [LEVEL_BITS-1:0]           i_goal_high,
    output logic [irbs_pkg::CLASS_BITS-1:0]      o_class
);

    logic in_bot, in_goal;

    assign in_bot  = (i_level >= i_bot_low) && (i_level <= i_bot_high);
    assign in_goal = (i_level >= i_goal_low) && (i_level <= i_goal_high);

    // The bot window takes precedence when the windows overlap.
    always_comb begin
        if (in_bot) begin
            o_class = irbs_pkg::CLASS_BOT;
        end else if (in_goal) begin
            o_class = irbs_pkg::CLASS_GOAL;
        end else begin
            o_class = irbs_pkg::CLASS_NONE;
        end
    end

endmodule

`default_nettype wire

// ----- sv/irbs_seek_core.sv -----
// Seek state machine: combines the sensor classes, moves the mode, steps the
// servo width and holds the result fields. Depends on irbs_pkg and irbs_classify.
`default_nettype none

module irbs_seek_core #(
    parameter int LEVEL_BITS = irbs_pkg::LEVEL_BITS_DEF,
    parameter int WIDTH_BITS = irbs_pkg::WIDTH_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_advance,
    input  wire logic [irbs_pkg::CMD_BITS-1:0]      i_command,
    input  wire logic [LEVEL_BITS-1:0]              i_left_level,
    input  wire logic [LEVEL_BITS-1:0]              i_right_level,
    input  wire logic [1:0]                         i_target_select,
    input  wire logic                               i_park_low,
    input  wire logic [LEVEL_BITS-1:0]              i_bot_low,
    input  wire logic [LEVEL_BITS-1:0]              i_bot_high,
    input  wire logic [LEVEL_BITS-1:0]              i_goal_low,
    input  wire logic [LEVEL_BITS-1:0]              i_goal_high,
    input  wire logic [WIDTH_BITS-1:0]              i_width_min,
    input  wire logic [WIDTH_BITS-1:0]              i_width_max,
    input  wire logic [WIDTH_BITS-1:0]              i_width_home,
    input  wire logic [irbs_pkg::STEP_BITS-1:0]     i_width_step,
    output logic [WIDTH_BITS-1:0]                   o_servo_width,
    output logic                                    o_servo_update,
    output logic [irbs_pkg::MODE_BITS-1:0]          o_mode,
    output logic [irbs_pkg::CODE_BITS-1:0]          o_sensed_code,
    output logic                                    o_sense_changed,
    output logic                                    o_deploy_request
);

    typedef enum logic [irbs_pkg::MODE_BITS-1:0] {
        MODE_OFF     = 3'd0,
        MODE_ACTIVE  = 3'd1,
        MODE_LEFT    = 3'd2,
        MODE_RIGHT   = 3'd3,
        MODE_ALIGNED = 3'd4
    } t_mode;

    t_mode                            r_mode, n_mode;
    logic [1:0]                       r_target, n_target;
    logic [WIDTH_BITS-1:0]            r_width, n_width;
    logic                             r_down, n_down;
    logic [irbs_pkg::CODE_BITS-1:0]   r_last, n_last;
    logic                             r_update, n_update;
    logic                             r_changed, n_changed;
    logic                             r_deploy, n_deploy;

    logic [irbs_pkg::CLASS_BITS-1:0]  left_class, right_class;
    logic [irbs_pkg::CODE_BITS-1:0]   code;
    logic                             dir_down;
    logic [WIDTH_BITS:0]              w_up;
    logic [WIDTH_BITS-1:0]            w_dn;
    logic                             w_neg;
    logic                             hit_max, hit_min;
    logic [WIDTH_BITS-1:0]            w_next;
    logic                             ticking;

    irbs_classify #(.LEVEL_BITS(LEVEL_BITS)) u_left (
        .i_level     (i_left_level),
        .i_bot_low   (i_bot_low),
        .i_bot_high  (i_bot_high),
        .i_goal_low  (i_goal_low),
        .i_goal_high (i_goal_high),
        .o_class     (left_class)
    );

    irbs_classify #(.LEVEL_BITS(LEVEL_BITS)) u_right (
        .i_level     (i_right_level),
        .i_bot_low   (i_bot_low),
        .i_bot_high  (i_bot_high),
        .i_goal_low  (i_goal_low),
        .i_goal_high (i_goal_high),
        .o_class     (right_class)
    );

    // A zero-frequency target matches two sensors that both see nothing.
    always_comb begin
        if ((left_class == right_class) && (right_class == r_target)) begin
            code = irbs_pkg::CODE_BOTH;
        end else if ((left_class != irbs_pkg::CLASS_NONE) && (left_class == r_target)) begin
            code = irbs_pkg::CODE_LEFT;
        end else if ((right_class != irbs_pkg::CLASS_NONE) && (right_class == r_target)) begin
            code = irbs_pkg::CODE_RIGHT;
        end else begin
            code = irbs_pkg::CODE_NONE;
        end
    end

    assign ticking = (r_mode == MODE_ACTIVE) || (r_mode == MODE_LEFT) || (r_mode == MODE_RIGHT);

    always_comb begin
        if (r_mode == MODE_LEFT) begin
            dir_down = 1'b1;
        end else if (r_mode == MODE_RIGHT) begin
            dir_down = 1'b0;
        end else begin
            dir_down = r_down;
        end
    end

    // The step is taken without wrapping; the maximum limit wins over the minimum.
    assign w_up  = {1'b0, r_width} + (WIDTH_BITS+1)'(i_width_step);
    assign w_dn  = r_width - WIDTH_BITS'(i_width_step);
    assign w_neg = r_width < WIDTH_BITS'(i_width_step);

    always_comb begin
        if (dir_down) begin
            hit_max = !w_neg && (w_dn >= i_width_max);
            hit_min = w_neg || (w_dn <= i_width_min);
            w_next  = w_dn;
        end else begin
            hit_max = w_up >= {1'b0, i_width_max};
            hit_min = w_up <= {1'b0, i_width_min};
            w_next  = w_up[WIDTH_BITS-1:0];
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_target  = r_target;
        n_width   = r_width;
        n_down    = r_down;
        n_last    = r_last;
        n_update  = 1'b0;
        n_changed = 1'b0;
        n_deploy  = 1'b0;
        case (i_command)
            irbs_pkg::CMD_SAMPLE: begin
                n_last = code;
                if (code != r_last) begin
                    n_changed = 1'b1;
                    if (r_mode != MODE_OFF) begin
                        case (code)
                            irbs_pkg::CODE_BOTH: begin
                                n_mode   = MODE_ALIGNED;
                                n_deploy = (r_target == irbs_pkg::CLASS_BOT);
                            end
                            irbs_pkg::CODE_LEFT:  n_mode = MODE_LEFT;
                            irbs_pkg::CODE_RIGHT: n_mode = MODE_RIGHT;
                            default:              n_mode = MODE_ACTIVE;
                        endcase
                    end
                end
            end
            irbs_pkg::CMD_TICK: begin
                if (ticking) begin
                    n_update = 1'b1;
                    if (hit_max) begin
                        n_width = i_width_max;
                        n_down  = 1'b1;
                    end else if (hit_min) begin
                        n_width = i_width_min;
                        n_down  = 1'b0;
                    end else begin
                        n_width = w_next;
                        n_down  = dir_down;
                    end
                end
            end
            irbs_pkg::CMD_START: begin
                n_target = i_target_select;
                n_mode   = MODE_ACTIVE;
            end
            default: begin
                if (r_mode != MODE_OFF) begin
                    n_mode   = MODE_OFF;
                    n_target = irbs_pkg::CLASS_NONE;
                    n_width  = i_park_low ? i_width_min : i_width_home;
                    n_update = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_target <= irbs_pkg::CLASS_BOT;
            r_width  <= WIDTH_BITS'(irbs_pkg::WIDTH_HOME_RST);
            r_down   <= 1'b0;
            r_last   <= irbs_pkg::CODE_NONE;
        end else if (i_advance) begin
            r_mode   <= n_mode;
            r_target <= n_target;
            r_width  <= n_width;
            r_down   <= n_down;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_update  <= n_update;
            r_changed <= n_changed;
            r_deploy  <= n_deploy;
        end
    end

    assign o_servo_width    = r_width;
    assign o_servo_update   = r_update;
    assign o_mode           = r_mode;
    assign o_sensed_code    = r_last;
    assign o_sense_changed  = r_changed;
    assign o_deploy_request = r_deploy;

endmodule

`default_nettype wire

// ----- sim/irbs_seek_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the IR beacon servo seek block. It watches the sample, result and
// register channels, predicts each result beat and compares it field by field.
// Depends on irbs_pkg.
module irbs_seek_checker #(
    parameter int IN_W   = 24,
    parameter int OUT_W  = 24,
    parameter int DATA_W = 12
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    input  wire logic                                i_s_tready,
    input  wire logic [IN_W-1:0]                     i_s_tdata,
    input  wire logic [irbs_pkg::CMD_BITS-1:0]       i_s_tuser,
    input  wire logic                                i_m_tvalid,
    input  wire logic                                i_m_tready,
    input  wire logic [OUT_W-1:0]                    i_m_tdata,
    input  wire logic                                i_cfg_valid,
    input  wire logic                                i_cfg_ready,
    input  wire logic [irbs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]                   i_cfg_data,
    output int                                       o_fail_count,
    output int                                       o_pending
);
    import irbs_pkg::*;

    localparam int LW = LEVEL_BITS_DEF;
    localparam int WW = WIDTH_BITS_DEF;

    localparam logic [MODE_BITS-1:0] MODE_OFF     = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_ACTIVE  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_LEFT    = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_RIGHT   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_ALIGNED = 3'd4;

    typedef struct packed {
        logic                  deploy;
        logic                  changed;
        logic [CODE_BITS-1:0]  code;
        logic [MODE_BITS-1:0]  mode;
        logic                  update;
        logic [WW-1:0]         width;
    } t_seek_result;

    localparam int RES_W = $bits(t_seek_result);

    logic [LW-1:0]         bot_lo, bot_hi, goal_lo, goal_hi;
    logic [WW-1:0]         w_min, w_max, w_home;
    logic [STEP_BITS-1:0]  w_step;

    logic [MODE_BITS-1:0]  mode_q;
    logic [CLASS_BITS-1:0] target_q;
    logic [WW-1:0]         width_q;
    logic                  sweep_dn;
    logic [CODE_BITS-1:0]  code_q;

    t_seek_result expected_q[$];
    int fails = 0;

    function automatic logic [CLASS_BITS-1:0] level_class(input logic [LW-1:0] lvl);
        if (lvl >= bot_lo && lvl <= bot_hi) return CLASS_BOT;
        if (lvl >= goal_lo && lvl <= goal_hi) return CLASS_GOAL;
        return CLASS_NONE;
    endfunction

    function automatic logic [CODE_BITS-1:0] aim_code(input logic [CLASS_BITS-1:0] lc,
                                                      input logic [CLASS_BITS-1:0] rc);
        if (lc == rc && rc == target_q) return CODE_BOTH;
        if (lc != CLASS_NONE && lc == target_q) return CODE_LEFT;
        if (rc != CLASS_NONE && rc == target_q) return CODE_RIGHT;
        return CODE_NONE;
    endfunction

    function automatic t_seek_result advance_seek(input logic [CMD_BITS-1:0] cmd,
                                                  input logic [IN_W-1:0] beat);
        logic [LW-1:0]         left_lvl;
        logic [LW-1:0]         right_lvl;
        logic [CLASS_BITS-1:0] tsel;
        logic                  park;
        logic [CODE_BITS-1:0]  code;
        int                    w;
        t_seek_result          r;
        left_lvl  = beat[LW-1:0];
        right_lvl = beat[2*LW-1:LW];
        tsel      = beat[2*LW+1:2*LW];
        park      = beat[2*LW+2];
        r = '0;
        case (cmd)
            CMD_SAMPLE: begin
                code = aim_code(level_class(left_lvl), level_class(right_lvl));
                if (code != code_q) begin
                    r.changed = 1'b1;
                    if (mode_q != MODE_OFF) begin
                        case (code)
                            CODE_BOTH: begin
                                mode_q = MODE_ALIGNED;
                                r.deploy = (target_q == CLASS_BOT);
                            end
                            CODE_LEFT:  mode_q = MODE_LEFT;
                            CODE_RIGHT: mode_q = MODE_RIGHT;
                            default:    mode_q = MODE_ACTIVE;
                        endcase
                    end
                end
                code_q = code;
            end
            CMD_TICK: begin
                if (mode_q == MODE_ACTIVE || mode_q == MODE_LEFT || mode_q == MODE_RIGHT) begin
                    if (mode_q == MODE_LEFT) sweep_dn = 1'b1;
                    else if (mode_q == MODE_RIGHT) sweep_dn = 1'b0;
                    w = sweep_dn ? int'(width_q) - int'(w_step) : int'(width_q) + int'(w_step);
                    if (w >= int'(w_max)) begin
                        sweep_dn = 1'b1;
                        w = int'(w_max);
                    end else if (w <= int'(w_min)) begin
                        sweep_dn = 1'b0;
                        w = int'(w_min);
                    end
                    width_q  = w[WW-1:0];
                    r.update = 1'b1;
                end
            end
            CMD_START: begin
                target_q = tsel;
                mode_q   = MODE_ACTIVE;
            end
            default: begin
                if (mode_q != MODE_OFF) begin
                    mode_q   = MODE_OFF;
                    target_q = CLASS_NONE;
                    width_q  = park ? w_min : w_home;
                    r.update = 1'b1;
                end
            end
        endcase
        r.width = width_q;
        r.mode  = mode_q;
        r.code  = code_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : beat_check
        t_seek_result exp_r;
        t_seek_result got_r;
        if (!i_rst_n) begin
            bot_lo   = LW'(BOT_LOW_RST);
            bot_hi   = LW'(BOT_HIGH_RST);
            goal_lo  = LW'(GOAL_LOW_RST);
            goal_hi  = LW'(GOAL_HIGH_RST);
            w_min    = WW'(WIDTH_MIN_RST);
            w_max    = WW'(WIDTH_MAX_RST);
            w_home   = WW'(WIDTH_HOME_RST);
            w_step   = STEP_BITS'(WIDTH_STEP_RST);
            mode_q   = MODE_OFF;
            target_q = CLASS_BOT;
            width_q  = WW'(WIDTH_HOME_RST);
            sweep_dn = 1'b0;
            code_q   = CODE_NONE;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_BOT_LOW:    bot_lo  = i_cfg_data[LW-1:0];
                    REG_BOT_HIGH:   bot_hi  = i_cfg_data[LW-1:0];
                    REG_GOAL_LOW:   goal_lo = i_cfg_data[LW-1:0];
                    REG_GOAL_HIGH:  goal_hi = i_cfg_data[LW-1:0];
                    REG_WIDTH_MIN:  w_min   = i_cfg_data[WW-1:0];
                    REG_WIDTH_MAX:  w_max   = i_cfg_data[WW-1:0];
                    REG_WIDTH_HOME: w_home  = i_cfg_data[WW-1:0];
                    default:        w_step  = i_cfg_data[STEP_BITS-1:0];
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got_r = i_m_tdata[RES_W-1:0];
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with none expected, expected nothing, got %h",
                             $time, got_r);
                    fails++;
                end else begin
                    exp_r = expected_q.pop_front();
                    check_field("servo_width", 16'(exp_r.width), 16'(got_r.width));
                    check_field("servo_update", 16'(exp_r.update), 16'(got_r.update));
                    check_field("mode", 16'(exp_r.mode), 16'(got_r.mode));
                    check_field("sensed_code", 16'(exp_r.code), 16'(got_r.code));
                    check_field("sense_changed", 16'(exp_r.changed), 16'(got_r.changed));
                    check_field("deploy_request", 16'(exp_r.deploy), 16'(got_r.deploy));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(advance_seek(i_s_tuser, i_s_tdata));
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

// ----- sim/tb_ir_beacon_servo_seek.sv -----
`timescale 1ns / 100ps
// Top of the IR beacon servo seek testbench: clock, reset, sample and register
// stimulus, result back-pressure, watchdog and verdict.
// Depends on irbs_pkg, ir_beacon_servo_seek and irbs_seek_checker.
module tb_ir_beacon_servo_seek;
    import irbs_pkg::*;

    localparam int LW     = LEVEL_BITS_DEF;
    localparam int WW     = WIDTH_BITS_DEF;
    localparam int IN_W   = 8 * ((2 * LW + 3 + 7) / 8);
    localparam int OUT_W  = 8 * ((WW + 8 + 7) / 8);
    localparam int DATA_W = (WW > LW) ? WW : LW;

    localparam int GAP_MAX         = 17;
    localparam int HOLD_CYCLES     = 80;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int TAIL_CYCLES     = 20;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic [IN_W-1:0]           s_tdata;
    logic [CMD_BITS-1:0]       s_tuser;
    wire                       s_tready;
    wire                       m_tvalid;
    logic                      m_tready;
    wire  [OUT_W-1:0]          m_tdata;
    logic                      cfg_valid;
    wire                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [DATA_W-1:0]         cfg_data;
    int                        fail_count;
    int                        pending;

    logic                      rx_hold;
    int                        tx_count = 0;
    int                        tx_style = 0;
    int                        idle_cycles = 0;
    logic [LW-1:0]             cur_bot_lo, cur_bot_hi, cur_goal_lo, cur_goal_hi;

    ir_beacon_servo_seek u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    irbs_seek_checker #(
        .IN_W   (IN_W),
        .OUT_W  (OUT_W),
        .DATA_W (DATA_W)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int draw_gap(input int style);
        case (style)
            0:       return 0;
            1:       return $urandom_range(0, GAP_MAX);
            default: return ($urandom_range(0, 5) == 0) ? $urandom_range(0, GAP_MAX) : 0;
        endcase
    endfunction

    function automatic logic [LW-1:0] near_bound(input logic [LW-1:0] lo, input logic [LW-1:0] hi);
        case ($urandom_range(0, 3))
            0:       return lo - 1'b1;
            1:       return lo;
            2:       return hi;
            default: return hi + 1'b1;
        endcase
    endfunction

    function automatic logic [LW-1:0] pick_level();
        case ($urandom_range(0, 9))
            0, 1, 2: return LW'($urandom_range(cur_bot_lo, cur_bot_hi));
            3, 4, 5: return LW'($urandom_range(cur_goal_lo, cur_goal_hi));
            6:       return near_bound(cur_bot_lo, cur_bot_hi);
            7:       return near_bound(cur_goal_lo, cur_goal_hi);
            default: return LW'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [LW-1:0] left_lvl,
                             input logic [LW-1:0] right_lvl, input logic [1:0] tsel,
                             input logic park);
        int gap;
        if (tx_count % 40 == 0) tx_style = $urandom_range(0, 2);
        gap = rx_hold ? 0 : draw_gap(tx_style);
        tx_count++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_W'({park, tsel, right_lvl, left_lvl});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_random_item();
        int                  pick;
        logic [CMD_BITS-1:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 50) cmd = CMD_SAMPLE;
        else if (pick < 85) cmd = CMD_TICK;
        else if (pick < 93) cmd = CMD_START;
        else cmd = CMD_STOP;
        send_item(cmd, pick_level(), pick_level(), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_setting(input int unsigned b_lo, input int unsigned b_hi,
                                input int unsigned g_lo, input int unsigned g_hi,
                                input int unsigned w_min, input int unsigned w_max,
                                input int unsigned w_home, input int unsigned w_step);
        write_reg(REG_BOT_LOW, b_lo);
        write_reg(REG_BOT_HIGH, b_hi);
        write_reg(REG_GOAL_LOW, g_lo);
        write_reg(REG_GOAL_HIGH, g_hi);
        write_reg(REG_WIDTH_MIN, w_min);
        write_reg(REG_WIDTH_MAX, w_max);
        write_reg(REG_WIDTH_HOME, w_home);
        write_reg(REG_WIDTH_STEP, w_step);
        cfg_valid   <= 1'b0;
        cur_bot_lo  = LW'(b_lo);
        cur_bot_hi  = LW'(b_hi);
        cur_goal_lo = LW'(g_lo);
        cur_goal_hi = LW'(g_hi);
    endtask

    task automatic run_phase();
        int n;
        for (n = 0; n < ITEMS_PER_PHASE; n++) send_random_item();
        drain();
    endtask

    task automatic run_random_setting();
        int unsigned b_lo, g_lo, w_lo;
        b_lo = $urandom_range(0, 1023);
        g_lo = $urandom_range(0, 1023);
        w_lo = $urandom_range(0, 2000);
        load_setting(b_lo, $urandom_range(b_lo, 1023), g_lo, $urandom_range(g_lo, 1023),
                     w_lo, $urandom_range(w_lo, 4095), $urandom_range(0, 4095),
                     $urandom_range(1, 255));
        run_phase();
    endtask

    initial begin : sink
        int gap;
        int beats;
        int rx_style;
        beats    = 0;
        rx_style = 0;
        rx_hold  <= 1'b0;
        forever begin
            if (beats % 40 == 0) rx_style = $urandom_range(0, 2);
            if (beats == 100 || beats == 700 || beats == 1300) begin
                rx_hold  <= 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold  <= 1'b0;
            end else begin
                gap = draw_gap(rx_style);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            beats++;
        end
    end

    initial begin : stimulus
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_SAMPLE;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_BOT_LOW;
        cfg_data    <= '0;
        cur_bot_lo  = LW'(BOT_LOW_RST);
        cur_bot_hi  = LW'(BOT_HIGH_RST);
        cur_goal_lo = LW'(GOAL_LOW_RST);
        cur_goal_hi = LW'(GOAL_HIGH_RST);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: tracking while off, sweep and clamp, each aligned mode and parks.
        send_item(CMD_SAMPLE, 300, 260, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0);
        send_item(CMD_STOP, 0, 0, 0, 1);
        send_item(CMD_START, 0, 0, CLASS_BOT, 0);
        send_item(CMD_TICK, 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0);
        send_item(CMD_SAMPLE, 240, 0, 3, 1);
        send_item(CMD_TICK, 1023, 1023, 3, 1);
        send_item(CMD_SAMPLE, 1023, 320, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0);
        send_item(CMD_SAMPLE, 320, 240, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0);
        send_item(CMD_SAMPLE, 239, 321, 0, 0);
        send_item(CMD_START, 0, 0, CLASS_GOAL, 0);
        send_item(CMD_SAMPLE, 425, 515, 0, 0);
        send_item(CMD_SAMPLE, 424, 516, 0, 0);
        send_item(CMD_START, 0, 0, CLASS_NONE, 0);
        send_item(CMD_SAMPLE, 0, 1023, 0, 0);
        send_item(CMD_START, 0, 0, 3, 0);
        send_item(CMD_SAMPLE, 250, 450, 0, 0);
        send_item(CMD_STOP, 0, 0, 0, 1);
        send_item(CMD_START, 0, 0, CLASS_BOT, 0);
        send_item(CMD_STOP, 0, 0, 0, 0);
        send_item(CMD_SAMPLE, 0, 0, 0, 0);
        drain();

        load_setting(0, 1023, 0, 1023, 0, 4095, 2048, 255);
        run_phase();
        load_setting(1023, 0, 600, 700, 3000, 1000, 4095, 1);
        run_phase();
        load_setting(500, 500, 500, 500, 100, 200, 150, 128);
        run_phase();
        load_setting(BOT_LOW_RST, BOT_HIGH_RST, GOAL_LOW_RST, GOAL_HIGH_RST,
                     WIDTH_MIN_RST, WIDTH_MAX_RST, WIDTH_HOME_RST, WIDTH_STEP_RST);
        run_phase();
        load_setting(0, 0, 1023, 1023, 4095, 4095, 0, 255);
        run_phase();
        load_setting(100, 400, 300, 700, 1000, 1100, 1050, 7);
        run_phase();
        run_random_setting();
        run_random_setting();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
